### sv/quaternion_mount_correction_top_defines.svh
// Assertion macros for the quaternion mount correction block.
// Used by quaternion_mount_correction_top; expects i_clk and i_rst_n in scope.
`ifndef QUATERNION_MOUNT_CORRECTION_TOP_DEFINES_SVH
`define QUATERNION_MOUNT_CORRECTION_TOP_DEFINES_SVH

// same-cycle implication
`define QMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qmc: implication check failed");

// next-cycle implication
`define QMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qmc: next-cycle check failed");

`endif

### sv/qmc_pkg.sv
// Package for the quaternion mount correction block: widths, item types,
// rotation table and sideband types. No dependencies.
package qmc_pkg;

    localparam int COMP_BITS   = 16;
    localparam int FRAC_BITS   = 14;
    localparam int ROT_BITS    = 32;
    localparam int PROD_BITS   = ROT_BITS + COMP_BITS;
    localparam int V_BITS      = PROD_BITS + 2;
    localparam int NRM_BITS    = 30;
    localparam int N_BITS      = 2 * NRM_BITS + 2;
    localparam int R_BITS      = NRM_BITS + 1;
    localparam int SQRT_STAGES = R_BITS;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int DIVW        = R_BITS + FRAC_BITS + 1;
    localparam int DIV_STAGES  = QUO_BITS + 1;
    localparam int CHUNKS      = (V_BITS + 7) / 8;
    localparam int CH_BITS     = $clog2(CHUNKS);
    localparam int POS_BITS    = CH_BITS + 3;
    localparam int LIM_INT     = ((1 << FRAC_BITS) < ((1 << (COMP_BITS - 1)) - 1)) ?
                                 (1 << FRAC_BITS) : ((1 << (COMP_BITS - 1)) - 1);
    localparam logic [QUO_BITS-1:0] RES_LIM = QUO_BITS'(LIM_INT);

    localparam logic signed [ROT_BITS-1:0] ONE30 = 32'sd1073741824;
    localparam logic signed [ROT_BITS-1:0] K45   = 32'sd759250125;
    localparam logic signed [ROT_BITS-1:0] KC22  = 32'sd992008094;
    localparam logic signed [ROT_BITS-1:0] KS22  = 32'sd410903207;
    localparam logic signed [ROT_BITS-1:0] KC30  = 32'sd929887697;
    localparam logic signed [ROT_BITS-1:0] KS30  = 32'sd536870912;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_PRESET = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] in_w;
        logic signed [COMP_BITS-1:0] in_x;
        logic signed [COMP_BITS-1:0] in_y;
        logic signed [COMP_BITS-1:0] in_z;
    } t_item_in;

    typedef struct packed {
        logic        [COMP_BITS-2:0] out_w;
        logic signed [COMP_BITS-1:0] out_x;
        logic signed [COMP_BITS-1:0] out_y;
        logic signed [COMP_BITS-1:0] out_z;
        logic                        zero_norm;
    } t_item_out;

    typedef logic signed [ROT_BITS-1:0] t_rot_c;
    typedef t_rot_c [3:0] t_rot;

    typedef struct packed {
        logic [3:0][NRM_BITS-1:0] mag;
        logic [3:0]               neg;
        logic                     flip;
        logic                     zero;
    } t_side;

    // conjugate of each mounting rotation, index 0 = w
    function automatic t_rot rot_coef(input logic [3:0] sel);
        t_rot a;
        a = '{default: '0};
        case (sel)
            4'd1: begin a[0] = K45;  a[2] = -K45; end
            4'd2: begin a[0] = K45;  a[2] = K45;  end
            4'd3: begin a[0] = KC22; a[1] = -KS22; end
            4'd4: begin a[0] = KC30; a[1] = -KS30; end
            4'd5: begin a[0] = K45;  a[1] = -K45; end
            4'd6: begin a[0] = KC22; a[1] = KS22; end
            4'd7: begin a[0] = KC30; a[1] = KS30; end
            4'd8: begin a[0] = K45;  a[1] = K45;  end
            default: begin a[0] = ONE30; end
        endcase
        return a;
    endfunction

endpackage

### sv/qmc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qmc_pkg; carries the t_side sideband alongside.
module qmc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [qmc_pkg::N_BITS-1:0] i_n,
    input  qmc_pkg::t_side             i_side,
    output logic                       o_vld,
    output logic [qmc_pkg::R_BITS-1:0] o_r,
    output qmc_pkg::t_side             o_side
);
    import qmc_pkg::*;

    logic              r_vld  [SQRT_STAGES];
    logic [N_BITS-1:0] r_rem  [SQRT_STAGES];
    logic [N_BITS-1:0] r_res  [SQRT_STAGES];
    t_side             r_side [SQRT_STAGES];
    logic [N_BITS-1:0] n_rem  [SQRT_STAGES];
    logic [N_BITS-1:0] n_res  [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_st
        localparam logic [N_BITS-1:0] BIT = N_BITS'(1) << (N_BITS - 2 - 2 * g);
        logic              vld_in;
        logic [N_BITS-1:0] rem_in;
        logic [N_BITS-1:0] res_in;
        logic [N_BITS-1:0] trial;
        t_side             side_in;

        if (g == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = i_n;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign res_in  = r_res[g-1];
            assign side_in = r_side[g-1];
        end

        assign trial = res_in + BIT;

        always_comb begin
            if (rem_in >= trial) begin
                n_rem[g] = rem_in - trial;
                n_res[g] = (res_in >> 1) + BIT;
            end else begin
                n_rem[g] = rem_in;
                n_res[g] = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_res[g]  <= n_res[g];
            r_side[g] <= side_in;
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_r    = r_res[SQRT_STAGES-1][R_BITS-1:0];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule

### sv/qmc_div.sv
// Four-lane pipelined restoring divider with rounding bias, one quotient bit
// per stage. Depends on qmc_pkg; carries the t_side sideband alongside.
module qmc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [qmc_pkg::R_BITS-1:0]          i_r,
    input  qmc_pkg::t_side                      i_side,
    output logic                                o_vld,
    output logic [3:0][qmc_pkg::QUO_BITS-1:0]   o_quo,
    output qmc_pkg::t_side                      o_side
);
    import qmc_pkg::*;

    logic                     r_i_vld;
    logic [3:0][DIVW-1:0]     r_i_rem;
    logic [DIVW-1:0]          r_i_den;
    t_side                    r_i_side;

    logic                     r_vld  [QUO_BITS];
    logic [3:0][DIVW-1:0]     r_rem  [QUO_BITS];
    logic [3:0][QUO_BITS-1:0] r_quo  [QUO_BITS];
    logic [DIVW-1:0]          r_den  [QUO_BITS];
    t_side                    r_side [QUO_BITS];
    logic [3:0][DIVW-1:0]     n_rem  [QUO_BITS];
    logic [3:0][QUO_BITS-1:0] n_quo  [QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_i_rem[i] <= (DIVW'(i_side.mag[i]) << FRAC_BITS) + DIVW'(i_r >> 1);
        end
        r_i_den  <= DIVW'(i_r);
        r_i_side <= i_side;
    end

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_st
        localparam int K = QUO_BITS - 1 - g;
        logic                     vld_in;
        logic [3:0][DIVW-1:0]     rem_in;
        logic [3:0][QUO_BITS-1:0] quo_in;
        logic [DIVW-1:0]          den_in;
        logic [DIVW-1:0]          den_sh;
        t_side                    side_in;

        if (g == 0) begin : g_first
            assign vld_in  = r_i_vld;
            assign rem_in  = r_i_rem;
            assign quo_in  = '0;
            assign den_in  = r_i_den;
            assign side_in = r_i_side;
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign quo_in  = r_quo[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
        end

        assign den_sh = den_in << K;

        always_comb begin
            n_rem[g] = rem_in;
            n_quo[g] = quo_in;
            for (int i = 0; i < 4; i++) begin
                if (rem_in[i] >= den_sh) begin
                    n_rem[g][i]    = rem_in[i] - den_sh;
                    n_quo[g][i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_quo[g]  <= n_quo[g];
            r_den[g]  <= den_in;
            r_side[g] <= side_in;
        end
    end

    assign o_vld  = r_vld[QUO_BITS-1];
    assign o_quo  = r_quo[QUO_BITS-1];
    assign o_side = r_side[QUO_BITS-1];

endmodule

### sv/quaternion_mount_correction_top.sv
// Quaternion mount correction top: rotation product, normalization, sign fix.
// Depends on qmc_pkg, qmc_sqrt, qmc_div and the assertion macro header.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------
//  item in  | start, busy (always low)     | i_item (t_item_in)
//  result   | o_valid, one-cycle strobe    | o_res (t_item_out)
//  config   | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Accepts one item every cycle; 56 register stages lie between the accepting edge
// and the result strobe: 8 front stages (products, sums, magnitude, byte search,
// shift amount, normalize, squares, sum), 31 square root stages, 16 divider stages
// and the output register.
// Synchronous reset clears valid bits and configuration.
// The receiver cannot stall, so the pipeline never holds.
`include "quaternion_mount_correction_top_defines.svh"

module quaternion_mount_correction_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  qmc_pkg::t_item_in    i_item,
    output logic                 o_valid,
    output qmc_pkg::t_item_out   o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data
);
    import qmc_pkg::*;

    logic       r_enable;
    logic [3:0] r_preset;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_preset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end else if (i_cfg_index == CFG_PRESET) begin
                r_preset <= i_cfg_data;
            end
        end
    end

    // s1: products
    t_rot                          rot;
    logic signed [COMP_BITS-1:0]   q      [4];
    logic                          r_s1_vld;
    logic signed [PROD_BITS-1:0]   r_s1_p [4][4];

    assign rot  = rot_coef(r_enable ? r_preset : 4'd0);
    assign q[0] = i_item.in_w;
    assign q[1] = i_item.in_x;
    assign q[2] = i_item.in_y;
    assign q[3] = i_item.in_z;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                r_s1_p[a][b] <= PROD_BITS'(rot[a]) * PROD_BITS'(q[b]);
            end
        end
    end

    // s2: Hamilton sums, r_s1_p[a][b] = rot[a] * q[b]
    logic                         r_s2_vld;
    logic signed [3:0][V_BITS-1:0] r_s2_v;

    always_ff @(posedge i_clk) begin
        r_s2_v[0] <= V_BITS'(r_s1_p[0][0]) - V_BITS'(r_s1_p[1][1])
                   - V_BITS'(r_s1_p[2][2]) - V_BITS'(r_s1_p[3][3]);
        r_s2_v[1] <= V_BITS'(r_s1_p[0][1]) + V_BITS'(r_s1_p[1][0])
                   + V_BITS'(r_s1_p[2][3]) - V_BITS'(r_s1_p[3][2]);
        r_s2_v[2] <= V_BITS'(r_s1_p[0][2]) - V_BITS'(r_s1_p[1][3])
                   + V_BITS'(r_s1_p[2][0]) + V_BITS'(r_s1_p[3][1]);
        r_s2_v[3] <= V_BITS'(r_s1_p[0][3]) + V_BITS'(r_s1_p[1][2])
                   - V_BITS'(r_s1_p[2][1]) + V_BITS'(r_s1_p[3][0]);
    end

    // s3: sign and magnitude
    logic                   r_s3_vld;
    logic [3:0][V_BITS-1:0] r_s3_mag;
    logic [3:0]             r_s3_neg;
    logic [V_BITS-1:0]      r_s3_or;
    logic [3:0][V_BITS-1:0] s3_mag;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s3_mag[i] = r_s2_v[i][V_BITS-1] ? V_BITS'(-r_s2_v[i]) : V_BITS'(r_s2_v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_mag <= s3_mag;
        r_s3_or  <= s3_mag[0] | s3_mag[1] | s3_mag[2] | s3_mag[3];
        for (int i = 0; i < 4; i++) begin
            r_s3_neg[i] <= r_s2_v[i][V_BITS-1];
        end
    end

    // s4: top nonzero byte
    logic                    r_s4_vld;
    logic [3:0][V_BITS-1:0]  r_s4_mag;
    logic [3:0]              r_s4_neg;
    logic [CHUNKS*8-1:0]     r_s4_pad;
    logic [CH_BITS-1:0]      r_s4_chunk;
    logic                    r_s4_zero;
    logic [CHUNKS*8-1:0]     s4_pad;
    logic [CH_BITS-1:0]      s4_chunk;

    assign s4_pad = (CHUNKS*8)'(r_s3_or);

    always_comb begin
        s4_chunk = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (|s4_pad[c*8 +: 8]) begin
                s4_chunk = CH_BITS'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_mag   <= r_s3_mag;
        r_s4_neg   <= r_s3_neg;
        r_s4_pad   <= s4_pad;
        r_s4_chunk <= s4_chunk;
        r_s4_zero  <= (r_s3_or == '0);
    end

    // s5: leading bit position and shift amount
    logic                   r_s5_vld;
    logic [3:0][V_BITS-1:0] r_s5_mag;
    logic [3:0]             r_s5_neg;
    logic                   r_s5_zero;
    logic                   r_s5_rdir;
    logic [POS_BITS-1:0]    r_s5_amt;
    logic [7:0]             s5_byte;
    logic [2:0]             s5_bit;
    logic [POS_BITS-1:0]    s5_pos;
    logic                   s5_rdir;

    assign s5_byte = r_s4_pad[r_s4_chunk*8 +: 8];

    always_comb begin
        s5_bit = '0;
        for (int b = 0; b < 8; b++) begin
            if (s5_byte[b]) begin
                s5_bit = 3'(b);
            end
        end
    end

    assign s5_pos  = {r_s4_chunk, s5_bit};
    assign s5_rdir = (s5_pos >= POS_BITS'(NRM_BITS - 1));

    always_ff @(posedge i_clk) begin
        r_s5_mag  <= r_s4_mag;
        r_s5_neg  <= r_s4_neg;
        r_s5_zero <= r_s4_zero;
        r_s5_rdir <= s5_rdir;
        r_s5_amt  <= s5_rdir ? s5_pos - POS_BITS'(NRM_BITS - 1)
                             : POS_BITS'(NRM_BITS - 1) - s5_pos;
    end

    // s6: normalize
    logic  r_s6_vld;
    t_side r_s6_side;
    t_side s6_side;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s6_side.mag[i] = r_s5_rdir ? NRM_BITS'(r_s5_mag[i] >> r_s5_amt)
                                       : NRM_BITS'(r_s5_mag[i] << r_s5_amt);
        end
        s6_side.neg  = r_s5_neg;
        s6_side.flip = r_s5_neg[0] && (s6_side.mag[0] != '0);
        s6_side.zero = r_s5_zero;
    end

    always_ff @(posedge i_clk) begin
        r_s6_side <= s6_side;
    end

    // s7: squares
    logic                       r_s7_vld;
    logic [3:0][2*NRM_BITS-1:0] r_s7_sq;
    t_side                      r_s7_side;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_s7_sq[i] <= (2*NRM_BITS)'(r_s6_side.mag[i]) * (2*NRM_BITS)'(r_s6_side.mag[i]);
        end
        r_s7_side <= r_s6_side;
    end

    // s8: sum of squares
    logic              r_s8_vld;
    logic [N_BITS-1:0] r_s8_n;
    t_side             r_s8_side;

    always_ff @(posedge i_clk) begin
        r_s8_n    <= N_BITS'(r_s7_sq[0]) + N_BITS'(r_s7_sq[1])
                   + N_BITS'(r_s7_sq[2]) + N_BITS'(r_s7_sq[3]);
        r_s8_side <= r_s7_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
        end
    end

    logic              sq_vld;
    logic [R_BITS-1:0] sq_r;
    t_side             sq_side;

    qmc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s8_vld),
        .i_n     (r_s8_n),
        .i_side  (r_s8_side),
        .o_vld   (sq_vld),
        .o_r     (sq_r),
        .o_side  (sq_side)
    );

    logic                     dv_vld;
    logic [3:0][QUO_BITS-1:0] dv_quo;
    t_side                    dv_side;

    qmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .i_r     (sq_r),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // output: clamp, sign, zero case
    logic [3:0][QUO_BITS-1:0]          res;
    logic signed [3:0][COMP_BITS-1:0]  sres;
    t_item_out                         n_res;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            res[i]  = (dv_quo[i] > RES_LIM) ? RES_LIM : dv_quo[i];
            sres[i] = (dv_side.neg[i] ^ dv_side.flip) ? COMP_BITS'(-COMP_BITS'(res[i]))
                                                      : COMP_BITS'(res[i]);
        end
        if (dv_side.zero) begin
            n_res = '0;
            n_res.zero_norm = 1'b1;
        end else begin
            n_res.out_w     = (COMP_BITS-1)'(res[0]);
            n_res.out_x     = sres[1];
            n_res.out_y     = sres[2];
            n_res.out_z     = sres[3];
            n_res.zero_norm = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

    `QMC_ASSERT_IMP(a_zero_clear, o_valid && o_res.zero_norm,
        o_res.out_w == '0 && o_res.out_x == '0 && o_res.out_y == '0 && o_res.out_z == '0)
    `QMC_ASSERT_IMP(a_w_range, o_valid, o_res.out_w <= (COMP_BITS-1)'(LIM_INT))
    `QMC_ASSERT_IMP(a_x_range, o_valid,
        o_res.out_x <= COMP_BITS'(LIM_INT) && o_res.out_x >= -COMP_BITS'(LIM_INT))
    `QMC_ASSERT_NEXT(a_cfg_enable, i_cfg_valid && i_cfg_index == CFG_ENABLE,
        r_enable == $past(i_cfg_data[0]))

endmodule

### sim/tb.sv
// Self-checking bench for quaternion_mount_correction_top: directed table, presets, random.
// Depends on qmc_pkg and top module; expected values: table rows or an internal predictor.
module tb;
    import qmc_pkg::*;

    localparam int LATENCY = 56;
    localparam longint CYCLE_LIMIT = 400000;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_IDLE, PH_BOTH} t_phase;

    typedef struct {
        t_item_in  item;
        logic      has_exp;
        t_item_out exp;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_item_in   i_item = '0;
    logic       o_valid;
    t_item_out  o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [3:0] i_cfg_data = '0;

    logic       corr_on;
    logic [3:0] corr_sel;
    t_item_out  expected_q[$];
    int         mismatches;
    longint     cycles;
    int         idle_pct;

    quaternion_mount_correction_top dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("quaternion_mount_correction_top verification failed");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_item_out e;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_res.out_w !== e.out_w) report("out_w", o_res.out_w, e.out_w);
                if (o_res.out_x !== e.out_x) report("out_x", o_res.out_x, e.out_x);
                if (o_res.out_y !== e.out_y) report("out_y", o_res.out_y, e.out_y);
                if (o_res.out_z !== e.out_z) report("out_z", o_res.out_z, e.out_z);
                if (o_res.zero_norm !== e.zero_norm)
                    report("zero_norm", o_res.zero_norm, e.zero_norm);
            end
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_item_out corrected_unit_quat(input t_item_in it);
        longint q[4], v[4], a[4];
        longint unsigned mag[4], res[4], m, n, r, lim;
        logic neg[4];
        t_item_out o;
        q[0] = it.in_w; q[1] = it.in_x; q[2] = it.in_y; q[3] = it.in_z;
        a = '{1073741824, 0, 0, 0};
        case (corr_sel)
            4'd1: a = '{759250125, 0, -759250125, 0};
            4'd2: a = '{759250125, 0, 759250125, 0};
            4'd3: a = '{992008094, -410903207, 0, 0};
            4'd4: a = '{929887697, -536870912, 0, 0};
            4'd5: a = '{759250125, -759250125, 0, 0};
            4'd6: a = '{992008094, 410903207, 0, 0};
            4'd7: a = '{929887697, 536870912, 0, 0};
            4'd8: a = '{759250125, 759250125, 0, 0};
            default: ;
        endcase
        if (corr_on) begin
            v[0] = a[0]*q[0] - a[1]*q[1] - a[2]*q[2] - a[3]*q[3];
            v[1] = a[0]*q[1] + a[1]*q[0] + a[2]*q[3] - a[3]*q[2];
            v[2] = a[0]*q[2] - a[1]*q[3] + a[2]*q[0] + a[3]*q[1];
            v[3] = a[0]*q[3] + a[1]*q[2] - a[2]*q[1] + a[3]*q[0];
        end else begin
            v = q;
        end
        m = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        o = '0;
        if (m == 0) begin
            o.zero_norm = 1'b1;
            return o;
        end
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        n = 0;
        for (int i = 0; i < 4; i++) n += mag[i] * mag[i];
        r = int_sqrt(n);
        lim = 64'd1 << FRAC_BITS;
        if (lim > (64'd1 << (COMP_BITS - 1)) - 1) lim = (64'd1 << (COMP_BITS - 1)) - 1;
        for (int i = 0; i < 4; i++) begin
            res[i] = ((mag[i] << FRAC_BITS) + (r >> 1)) / r;
            if (res[i] > lim) res[i] = lim;
        end
        if (neg[0] && mag[0] != 0)
            for (int i = 0; i < 4; i++) neg[i] = !neg[i];
        o.out_w = res[0][COMP_BITS-2:0];
        o.out_x = neg[1] ? -res[1][COMP_BITS-1:0] : res[1][COMP_BITS-1:0];
        o.out_y = neg[2] ? -res[2][COMP_BITS-1:0] : res[2][COMP_BITS-1:0];
        o.out_z = neg[3] ? -res[3][COMP_BITS-1:0] : res[3][COMP_BITS-1:0];
        return o;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ENABLE) corr_on = data[0];
        else if (idx == CFG_PRESET) corr_sel = data;
        @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_item(input t_item_in it, input logic has_exp, input t_item_out exp);
        t_item_out p;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        p = corrected_unit_quat(it);
        if (has_exp && p !== exp) report("directed table row", p, exp);
        expected_q.push_back(has_exp ? exp : p);
    endtask

    function automatic t_item_in rand_item();
        t_item_in it;
        int k;
        it = t_item_in'({$urandom, $urandom});
        k = $urandom_range(9);
        if (k == 0) it = '0;
        else if (k == 1) it.in_w = 16'sh8000;
        else if (k == 2) begin
            it.in_x = '0;
            it.in_y = '0;
            it.in_z = '0;
        end else if (k == 3) begin
            it.in_w = 16'(int'($urandom_range(3)) - 1);
            it.in_x = 16'(int'($urandom_range(3)) - 1);
        end
        return it;
    endfunction

    function automatic t_item_out unit_out(input logic [14:0] w, input logic signed [15:0] x,
                                           input logic signed [15:0] y,
                                           input logic signed [15:0] z, input logic zn);
        t_item_out o;
        o.out_w = w;
        o.out_x = x;
        o.out_y = y;
        o.out_z = z;
        o.zero_norm = zn;
        return o;
    endfunction

    initial begin
        t_row rows[$];
        t_row rw;
        t_phase ph;
        int total;
        cycles = 0;
        mismatches = 0;
        corr_on = 1'b0;
        corr_sel = 4'd0;
        idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rw.has_exp = 1'b1;
        rw.item = '0; rw.exp = unit_out(0, 0, 0, 0, 1); rows.push_back(rw);
        rw.item = '{16'sd16384, 0, 0, 0}; rw.exp = unit_out(16384, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.item = '{16'sh8000, 0, 0, 0}; rw.exp = unit_out(16384, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.item = '{16'sh7fff, 0, 0, 0}; rw.exp = unit_out(16384, 0, 0, 0, 0);
        rows.push_back(rw);
        rw.item = '{0, 16'sh8000, 0, 0}; rw.exp = unit_out(0, -16384, 0, 0, 0);
        rows.push_back(rw);
        rw.item = '{0, 0, 16'sh7fff, 0}; rw.exp = unit_out(0, 0, 16384, 0, 0);
        rows.push_back(rw);
        rw.item = '{0, 0, 0, -1}; rw.exp = unit_out(0, 0, 0, -16384, 0); rows.push_back(rw);
        rw.item = '{-1, 0, 0, 1}; rw.exp = unit_out(11585, 0, 0, -11585, 0);
        rows.push_back(rw);
        rw.has_exp = 1'b0;
        rw.item = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(rw);
        rw.item = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; rows.push_back(rw);
        rw.item = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; rows.push_back(rw);
        rw.item = '{1, 2, 3, 4}; rows.push_back(rw);

        foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
        drain();

        write_reg(CFG_ENABLE, 4'd1);
        for (int s = 0; s <= 15; s++) begin
            write_reg(CFG_PRESET, s[3:0]);
            foreach (rows[i]) send_item(rows[i].item, 1'b0, '0);
            drain();
        end

        total = 0;
        for (int blk = 0; blk < 16; blk++) begin
            ph = t_phase'(blk % 4);
            idle_pct = (ph == PH_SEND_IDLE) ? 56 : (ph == PH_BOTH) ? 20 : 0;
            write_reg(CFG_ENABLE, 4'($urandom_range(1)));
            write_reg(CFG_PRESET, (blk % 5 == 0) ? 4'd8 : 4'($urandom_range(15)));
            for (int k = 0; k < 115; k++) begin
                send_item(rand_item(), 1'b0, '0);
                total++;
            end
            drain();
        end

        idle_pct = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("quaternion_mount_correction_top verification clean");
        else
            $display("quaternion_mount_correction_top verification failed");
        $finish;
    end
endmodule
